// ===== design/erls_pkg.sv =====
// Package with the request and response types and constants of the event rate limiter.
package erls_pkg;

   localparam int COUNT_BITS    = 24;
   localparam int VALUE_BITS    = 32;
   localparam int TYPE_COUNT    = 8;
   localparam int TYPE_BITS     = 3;
   localparam int TALLIED_TYPES = 5;
   localparam int CMD_BITS      = 2;
   localparam int RATE_BITS     = 32;
   localparam int THRESH_BITS   = 33;
   localparam int PRODUCT_BITS  = 64;
   localparam int SCALED_BITS   = COUNT_BITS + 20;
   localparam int WINDOW_SCALE  = 1000000;

   localparam logic [31:0] DEFAULT_SEED = 32'd2463534242;

   localparam logic [CMD_BITS-1:0] CMD_EVENT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_BEGIN = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_END   = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_STEP  = 2'd3;

   localparam int ADDR_BITS = 6;
   localparam int DATA_BITS = 64;
   localparam int INDEX_BITS = 3;

   localparam logic [INDEX_BITS-1:0] REG_ENABLED   = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_MAX_STEP  = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_MAX_SEC   = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_THRESHOLD = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_MASK      = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_SEED      = 3'd5;

   typedef struct packed {
      logic [CMD_BITS-1:0]          cmd;
      logic [TYPE_BITS-1:0]         event_type;
      logic signed [VALUE_BITS-1:0] energy_delta;
      logic [VALUE_BITS-1:0]        force_magnitude;
      logic [31:0]                  elapsed_us;
   } req_type;

   typedef struct packed {
      logic                    pass_event;
      logic                    limiter_active;
      logic [COUNT_BITS-1:0]   total_count;
      logic [COUNT_BITS-1:0]   passed_count;
      logic [COUNT_BITS-1:0]   collision_count;
      logic [COUNT_BITS-1:0]   bond_made_count;
      logic [COUNT_BITS-1:0]   bond_broken_count;
      logic [COUNT_BITS-1:0]   anomaly_count;
      logic [COUNT_BITS-1:0]   spike_count;
      logic [VALUE_BITS-2:0]   peak_energy;
      logic [VALUE_BITS-1:0]   peak_force;
   } rsp_type;

endpackage

// ===== design/event_rate_limiter_sampler_unit.sv =====
// Top level of the event rate limiter with xorshift32 sampling.
// The block takes one request per cycle unless the response side stalls, and returns one
// response per request. Requests pass through an input register and a stage that forms
// the end-window rate product, max_per_second times the clamped elapsed time, with one
// 32 by 32 multiplier; the statistics, the window count and the generator state are
// updated from that stage by a single-cycle loop, and the response is held in an output
// register until taken. The user must write configuration through the APB port while
// no request is in flight; the block itself does not enforce this. A seed write also
// reloads the generator, and a zero seed loads the default seed.
module event_rate_limiter_sampler_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  erls_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output erls_pkg::rsp_type         rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [erls_pkg::ADDR_BITS-1:0] paddr,
   input  logic [erls_pkg::DATA_BITS-1:0] pwdata,
   output logic [erls_pkg::DATA_BITS-1:0] prdata,
   output logic                      pready
);
   import erls_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [VALUE_BITS-2:0] MAG_MAX = {(VALUE_BITS-1){1'b1}};

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [31:0] xorshift(input logic [31:0] w);
      logic [31:0] x;
      x = w ^ (w << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   logic                    enabled_ff;
   logic [COUNT_BITS-1:0]   max_step_ff;
   logic [RATE_BITS-1:0]    max_sec_ff;
   logic [THRESH_BITS-1:0]  threshold_ff;
   logic [TYPE_COUNT-1:0]   mask_ff;
   logic [31:0]             seed_ff;

   logic [INDEX_BITS-1:0]   csr_index;
   logic                    csr_write;
   logic [31:0]             seed_value;

   logic                    s1_valid_ff;
   req_type                 s1_item_ff;
   logic                    s2_valid_ff;
   req_type                 s2_item_ff;
   logic [PRODUCT_BITS-1:0] s2_rate_ff;
   logic [PRODUCT_BITS-1:0] rate_in;
   logic [31:0]             elapsed_clamped;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   logic                    out_free;
   logic                    s2_move;
   logic                    s2_free;
   logic                    s1_free;

   logic [31:0]             rng_word_ff, rng_word_in;
   logic [COUNT_BITS-1:0]   window_count_ff, window_count_in;
   logic [SCALED_BITS-1:0]  window_scaled_ff, window_scaled_in;
   logic                    active_ff, active_in;
   logic [COUNT_BITS-1:0]   seen_ff, seen_in;
   logic [COUNT_BITS-1:0]   passed_ff, passed_in;
   logic [COUNT_BITS-1:0]   tally_ff [TALLIED_TYPES];
   logic [COUNT_BITS-1:0]   tally_in [TALLIED_TYPES];
   logic [VALUE_BITS-2:0]   energy_peak_ff, energy_peak_in;
   logic [VALUE_BITS-1:0]   force_peak_ff, force_peak_in;

   logic [31:0]             draw_word;
   logic [VALUE_BITS-1:0]   energy_neg;
   logic [VALUE_BITS-2:0]   energy_mag;
   logic                    bypass;
   logic                    pass_bit;

   assign pready    = 1'b1;
   assign csr_index = paddr[ADDR_BITS-1:3];
   assign csr_write = psel && penable && pwrite;
   assign seed_value = (pwdata[31:0] == 32'd0) ? DEFAULT_SEED : pwdata[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         max_step_ff  <= COUNT_BITS'(100);
         max_sec_ff   <= RATE_BITS'(10000);
         threshold_ff <= {1'b1, {(THRESH_BITS-1){1'b0}}};
         mask_ff      <= '0;
         seed_ff      <= DEFAULT_SEED;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ENABLED:   enabled_ff   <= pwdata[0];
            REG_MAX_STEP:  max_step_ff  <= pwdata[COUNT_BITS-1:0];
            REG_MAX_SEC:   max_sec_ff   <= pwdata[RATE_BITS-1:0];
            REG_THRESHOLD: threshold_ff <= pwdata[THRESH_BITS-1:0];
            REG_MASK:      mask_ff      <= pwdata[TYPE_COUNT-1:0];
            REG_SEED:      seed_ff      <= seed_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENABLED:   prdata = DATA_BITS'(enabled_ff);
         REG_MAX_STEP:  prdata = DATA_BITS'(max_step_ff);
         REG_MAX_SEC:   prdata = DATA_BITS'(max_sec_ff);
         REG_THRESHOLD: prdata = DATA_BITS'(threshold_ff);
         REG_MASK:      prdata = DATA_BITS'(mask_ff);
         REG_SEED:      prdata = DATA_BITS'(seed_ff);
         default:       prdata = '0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign elapsed_clamped = (s1_item_ff.elapsed_us == 32'd0) ? 32'd1 : s1_item_ff.elapsed_us;
   assign rate_in = PRODUCT_BITS'(max_sec_ff) * PRODUCT_BITS'(elapsed_clamped);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_free && req_valid) begin
         s1_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_free && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_rate_ff <= rate_in;
      end
   end

   assign draw_word  = xorshift(rng_word_ff);
   assign energy_neg = VALUE_BITS'(0) - s2_item_ff.energy_delta;

   always_comb begin
      if (s2_item_ff.energy_delta[VALUE_BITS-1]) begin
         energy_mag = energy_neg[VALUE_BITS-1] ? MAG_MAX : energy_neg[VALUE_BITS-2:0];
      end else begin
         energy_mag = s2_item_ff.energy_delta[VALUE_BITS-2:0];
      end
   end

   assign bypass = !enabled_ff || mask_ff[s2_item_ff.event_type];

   always_comb begin
      rng_word_in      = rng_word_ff;
      window_count_in  = window_count_ff;
      window_scaled_in = window_scaled_ff;
      active_in        = active_ff;
      seen_in          = seen_ff;
      passed_in        = passed_ff;
      tally_in         = tally_ff;
      energy_peak_in   = energy_peak_ff;
      force_peak_in    = force_peak_ff;
      pass_bit         = 1'b0;
      if (s2_move) begin
         unique case (s2_item_ff.cmd)
            CMD_EVENT: begin
               seen_in         = sat_inc(seen_ff);
               window_count_in = sat_inc(window_count_ff);
               if (window_count_ff != COUNT_MAX) begin
                  window_scaled_in = window_scaled_ff + SCALED_BITS'(WINDOW_SCALE);
               end
               if (energy_mag > energy_peak_ff) begin
                  energy_peak_in = energy_mag;
               end
               if (s2_item_ff.force_magnitude > force_peak_ff) begin
                  force_peak_in = s2_item_ff.force_magnitude;
               end
               for (int i = 0; i < TALLIED_TYPES; i++) begin
                  if (s2_item_ff.event_type == TYPE_BITS'(i)) begin
                     tally_in[i] = sat_inc(tally_ff[i]);
                  end
               end
               if (bypass) begin
                  pass_bit = 1'b1;
               end else if (passed_ff >= max_step_ff) begin
                  pass_bit = 1'b0;
               end else if (active_ff) begin
                  rng_word_in = draw_word;
                  pass_bit    = !({1'b0, draw_word} > threshold_ff);
               end else begin
                  pass_bit = 1'b1;
               end
               if (pass_bit) begin
                  passed_in = sat_inc(passed_ff);
               end
            end
            CMD_BEGIN: begin
               window_count_in  = '0;
               window_scaled_in = '0;
            end
            CMD_END: begin
               active_in = enabled_ff && ((window_count_ff > max_step_ff) ||
                           (PRODUCT_BITS'(window_scaled_ff) > s2_rate_ff));
            end
            CMD_STEP: begin
               seen_in        = '0;
               passed_in      = '0;
               energy_peak_in = '0;
               force_peak_in  = '0;
               for (int i = 0; i < TALLIED_TYPES; i++) begin
                  tally_in[i] = '0;
               end
            end
            default: ;
         endcase
      end
      if (csr_write && csr_index == REG_SEED) begin
         rng_word_in = seed_value;
      end
   end

   always_comb begin
      rsp_in.pass_event        = pass_bit;
      rsp_in.limiter_active    = active_in;
      rsp_in.total_count       = seen_in;
      rsp_in.passed_count      = passed_in;
      rsp_in.collision_count   = tally_in[0];
      rsp_in.bond_made_count   = tally_in[1];
      rsp_in.bond_broken_count = tally_in[2];
      rsp_in.anomaly_count     = tally_in[3];
      rsp_in.spike_count       = tally_in[4];
      rsp_in.peak_energy       = energy_peak_in;
      rsp_in.peak_force        = force_peak_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_word_ff      <= DEFAULT_SEED;
         window_count_ff  <= '0;
         window_scaled_ff <= '0;
         active_ff        <= 1'b0;
         seen_ff          <= '0;
         passed_ff        <= '0;
         for (int i = 0; i < TALLIED_TYPES; i++) begin
            tally_ff[i] <= '0;
         end
         energy_peak_ff   <= '0;
         force_peak_ff    <= '0;
      end else begin
         rng_word_ff      <= rng_word_in;
         window_count_ff  <= window_count_in;
         window_scaled_ff <= window_scaled_in;
         active_ff        <= active_in;
         seen_ff          <= seen_in;
         passed_ff        <= passed_in;
         tally_ff         <= tally_in;
         energy_peak_ff   <= energy_peak_in;
         force_peak_ff    <= force_peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s2_move) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the event rate limiter with xorshift32 sampling.
`timescale 1ns / 1ps

module testbench;
   import erls_pkg::*;

   localparam logic [INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   event_rate_limiter_sampler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Settings and state as the limiter should hold them.
   logic                   limiter_on;
   logic [COUNT_BITS-1:0]  step_cap;
   logic [RATE_BITS-1:0]   rate_cap;
   logic [THRESH_BITS-1:0] keep_threshold;
   logic [TYPE_COUNT-1:0]  bypass_mask;
   logic [31:0]            shift_state;
   logic [COUNT_BITS-1:0]  window_events;
   logic                   sampling_on;
   logic [COUNT_BITS-1:0]  events_seen;
   logic [COUNT_BITS-1:0]  events_passed;
   logic [COUNT_BITS-1:0]  type_tally [TALLIED_TYPES];
   logic [VALUE_BITS-2:0]  energy_max;
   logic [VALUE_BITS-1:0]  force_max;

   rsp_type     predicted_responses [$];
   int unsigned mismatch_count = 0;
   int unsigned send_idle = 27;
   int unsigned recv_idle = 83;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_TOP) ? v : v + 1'b1;
   endfunction

   function automatic rsp_type predict_response(input req_type item);
      rsp_type               want;
      logic [31:0]           raw;
      logic [31:0]           draw;
      logic [31:0]           span;
      logic [VALUE_BITS-2:0] magnitude;
      logic [63:0]           scaled;
      logic [63:0]           allowed;
      logic                  passed;
      passed = 1'b0;
      case (item.cmd)
         CMD_EVENT: begin
            raw = item.energy_delta;
            if (raw[31]) begin
               raw = -raw;
               magnitude = raw[31] ? '1 : raw[30:0];
            end else begin
               magnitude = raw[30:0];
            end
            events_seen = bump(events_seen);
            window_events = bump(window_events);
            if (magnitude > energy_max) energy_max = magnitude;
            if (item.force_magnitude > force_max) force_max = item.force_magnitude;
            if (item.event_type < TALLIED_TYPES)
               type_tally[item.event_type] = bump(type_tally[item.event_type]);
            passed = 1'b1;
            if (limiter_on && !bypass_mask[item.event_type]) begin
               if (events_passed >= step_cap) begin
                  passed = 1'b0;
               end else if (sampling_on) begin
                  draw = shift_state;
                  draw ^= draw << 13;
                  draw ^= draw >> 17;
                  draw ^= draw << 5;
                  shift_state = draw;
                  if ({1'b0, draw} > keep_threshold) passed = 1'b0;
               end
            end
            if (passed) events_passed = bump(events_passed);
         end
         CMD_BEGIN: window_events = '0;
         CMD_END: begin
            span = (item.elapsed_us == 0) ? 32'd1 : item.elapsed_us;
            scaled = 64'(window_events) * 64'(WINDOW_SCALE);
            allowed = 64'(rate_cap) * 64'(span);
            sampling_on = limiter_on && (window_events > step_cap || scaled > allowed);
         end
         CMD_STEP: begin
            events_seen = '0;
            events_passed = '0;
            for (int i = 0; i < TALLIED_TYPES; i++) type_tally[i] = '0;
            energy_max = '0;
            force_max = '0;
         end
      endcase
      want.pass_event = passed;
      want.limiter_active = sampling_on;
      want.total_count = events_seen;
      want.passed_count = events_passed;
      want.collision_count = type_tally[0];
      want.bond_made_count = type_tally[1];
      want.bond_broken_count = type_tally[2];
      want.anomaly_count = type_tally[3];
      want.spike_count = type_tally[4];
      want.peak_energy = energy_max;
      want.peak_force = force_max;
      return want;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 50)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_response(input rsp_type got, input rsp_type want);
      if (got.pass_event !== want.pass_event)
         report_mismatch("pass_event", 32'(got.pass_event), 32'(want.pass_event));
      if (got.limiter_active !== want.limiter_active)
         report_mismatch("limiter_active", 32'(got.limiter_active),
                         32'(want.limiter_active));
      if (got.total_count !== want.total_count)
         report_mismatch("total_count", 32'(got.total_count), 32'(want.total_count));
      if (got.passed_count !== want.passed_count)
         report_mismatch("passed_count", 32'(got.passed_count), 32'(want.passed_count));
      if (got.collision_count !== want.collision_count)
         report_mismatch("collision_count", 32'(got.collision_count),
                         32'(want.collision_count));
      if (got.bond_made_count !== want.bond_made_count)
         report_mismatch("bond_made_count", 32'(got.bond_made_count),
                         32'(want.bond_made_count));
      if (got.bond_broken_count !== want.bond_broken_count)
         report_mismatch("bond_broken_count", 32'(got.bond_broken_count),
                         32'(want.bond_broken_count));
      if (got.anomaly_count !== want.anomaly_count)
         report_mismatch("anomaly_count", 32'(got.anomaly_count), 32'(want.anomaly_count));
      if (got.spike_count !== want.spike_count)
         report_mismatch("spike_count", 32'(got.spike_count), 32'(want.spike_count));
      if (got.peak_energy !== want.peak_energy)
         report_mismatch("peak_energy", 32'(got.peak_energy), 32'(want.peak_energy));
      if (got.peak_force !== want.peak_force)
         report_mismatch("peak_force", got.peak_force, want.peak_force);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_responses.size() == 0)
            report_mismatch("response with no request pending", 32'(rsp_data.total_count),
                            32'd0);
         else
            check_response(rsp_data, predicted_responses.pop_front());
      end
   end

   function automatic req_type make_request(input logic [CMD_BITS-1:0] cmd,
                                            input int unsigned kind,
                                            input logic [31:0] energy,
                                            input logic [31:0] force_value,
                                            input logic [31:0] elapsed);
      req_type item;
      item.cmd = cmd;
      item.event_type = TYPE_BITS'(kind);
      item.energy_delta = energy;
      item.force_magnitude = force_value;
      item.elapsed_us = elapsed;
      return item;
   endfunction

   function automatic req_type random_event();
      logic [31:0] energy;
      logic [31:0] force_value;
      case ($urandom_range(5))
         0: energy = 32'h8000_0000;
         1: energy = 32'h7FFF_FFFF;
         2: energy = '0;
         3: energy = '1;
         default: energy = $urandom;
      endcase
      case ($urandom_range(4))
         0: force_value = '0;
         1: force_value = '1;
         default: force_value = $urandom;
      endcase
      return make_request(CMD_EVENT, $urandom_range(TYPE_COUNT - 1), energy, force_value,
                          $urandom);
   endfunction

   function automatic logic [31:0] random_elapsed();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return $urandom_range(1, 3000);
      endcase
   endfunction

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predicted_responses.push_back(predict_response(item));
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (predicted_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [INDEX_BITS-1:0] index,
                                 input logic [DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_ENABLED:   limiter_on = value[0];
         REG_MAX_STEP:  step_cap = value[COUNT_BITS-1:0];
         REG_MAX_SEC:   rate_cap = value[RATE_BITS-1:0];
         REG_THRESHOLD: keep_threshold = value[THRESH_BITS-1:0];
         REG_MASK:      bypass_mask = value[TYPE_COUNT-1:0];
         REG_SEED: begin
            shift_state = (value[31:0] == 0) ? DEFAULT_SEED : value[31:0];
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(make_request(CMD_EVENT, 0, 32'h0, 32'h0, 32'h0));
      send_request(make_request(CMD_EVENT, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '1));
      send_request(make_request(CMD_EVENT, 2, 32'h8000_0000, 32'h1, 32'h0));
      send_request(make_request(CMD_EVENT, 3, 32'hFFFF_FFFF, 32'h0, 32'h0));
      send_request(make_request(CMD_EVENT, 4, 32'h0001_0000, 32'h0, 32'h0));
      send_request(make_request(CMD_EVENT, 5, $urandom, $urandom, $urandom));
      send_request(make_request(CMD_EVENT, 6, $urandom, $urandom, $urandom));
      send_request(make_request(CMD_EVENT, 7, $urandom, $urandom, $urandom));
      // A zero window length counts as one microsecond, so this window is over rate.
      send_request(make_request(CMD_END, 0, 32'h0, 32'h0, 32'h0));
      repeat (3) send_request(random_event());
      send_request(make_request(CMD_BEGIN, 7, '1, '1, '1));
      send_request(make_request(CMD_END, 0, 32'h0, 32'h0, 32'hFFFF_FFFF));
      send_request(make_request(CMD_STEP, 0, '1, '1, '1));
      send_request(make_request(CMD_EVENT, 0, 32'h8000_0000, 32'h0, 32'h0));
   endtask

   task automatic test_register_settings();
      wait_until_idle();
      write_register(REG_SPARE_LO, '1);
      write_register(REG_SPARE_HI, '1);
      write_register(REG_ENABLED, 64'd0);
      repeat (2) send_request(random_event());
      send_request(make_request(CMD_END, 0, 32'h0, 32'h0, 32'h0));
      wait_until_idle();
      write_register(REG_ENABLED, 64'd1);
      write_register(REG_MAX_STEP, 64'd0);
      send_request(make_request(CMD_EVENT, 0, 32'h10, 32'h10, 32'h0));
      send_request(make_request(CMD_EVENT, 3, 32'h10, 32'h10, 32'h0));
      wait_until_idle();
      write_register(REG_MASK, 64'h09);
      send_request(make_request(CMD_EVENT, 0, 32'h20, 32'h20, 32'h0));
      send_request(make_request(CMD_EVENT, 3, 32'h20, 32'h20, 32'h0));
      send_request(make_request(CMD_EVENT, 1, 32'h20, 32'h20, 32'h0));
      wait_until_idle();
      write_register(REG_MAX_STEP, 64'hFF_FFFF);
      write_register(REG_MASK, 64'h0);
      write_register(REG_SEED, 64'd0);
      write_register(REG_THRESHOLD, 64'd0);
      write_register(REG_MAX_SEC, 64'd0);
      send_request(make_request(CMD_BEGIN, 0, 32'h0, 32'h0, 32'h0));
      send_request(random_event());
      send_request(make_request(CMD_END, 0, 32'h0, 32'h0, 32'd5));
      repeat (4) send_request(random_event());
      wait_until_idle();
      write_register(REG_SEED, 64'hFFFF_FFFF);
      write_register(REG_THRESHOLD, 64'h8000_0000);
      repeat (3) send_request(random_event());
   endtask

   task automatic program_random_settings();
      wait_until_idle();
      write_register(REG_ENABLED, 64'($urandom_range(3) != 0));
      case ($urandom_range(3))
         0: write_register(REG_MAX_STEP, 64'd0);
         1: write_register(REG_MAX_STEP, 64'hFF_FFFF);
         2: write_register(REG_MAX_STEP, 64'($urandom_range(1, 40)));
         default: write_register(REG_MAX_STEP, 64'($urandom_range(1000, 24'hFF_FFFF)));
      endcase
      case ($urandom_range(3))
         0: write_register(REG_MAX_SEC, 64'd0);
         1: write_register(REG_MAX_SEC, 64'hFFFF_FFFF);
         2: write_register(REG_MAX_SEC, 64'($urandom_range(1, 100000)));
         default: write_register(REG_MAX_SEC, 64'($urandom));
      endcase
      case ($urandom_range(3))
         0: write_register(REG_THRESHOLD, 64'd0);
         1: write_register(REG_THRESHOLD, 64'h1_0000_0000);
         2: write_register(REG_THRESHOLD, 64'hFFFF_FFFF);
         default: write_register(REG_THRESHOLD, 64'($urandom));
      endcase
      case ($urandom_range(3))
         0: write_register(REG_MASK, 64'h00);
         1: write_register(REG_MASK, 64'hFF);
         default: write_register(REG_MASK, 64'($urandom_range(255)));
      endcase
      case ($urandom_range(3))
         0: write_register(REG_SEED, 64'd0);
         1: write_register(REG_SEED, 64'hFFFF_FFFF);
         default: write_register(REG_SEED, 64'($urandom));
      endcase
   endtask

   // Mostly whole windows of events with random content, with some step resets and noise.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned burst;
      req_type     noise;
      logic [127:0] noise_bits;
      for (int segment = 0; segment < 4; segment++) begin
         program_random_settings();
         sent = 0;
         while (sent < 40) begin
            case ($urandom_range(9))
               7: begin
                  send_request(make_request(CMD_STEP, $urandom, $urandom, $urandom,
                                            $urandom));
                  sent++;
               end
               8, 9: begin
                  noise_bits = {$urandom, $urandom, $urandom, $urandom};
                  noise = noise_bits[$bits(req_type)-1:0];
                  send_request(noise);
                  sent++;
               end
               default: begin
                  burst = $urandom_range(0, 20);
                  send_request(make_request(CMD_BEGIN, $urandom, $urandom, $urandom,
                                            $urandom));
                  repeat (burst) send_request(random_event());
                  send_request(make_request(CMD_END, $urandom, $urandom, $urandom,
                                            random_elapsed()));
                  sent += burst + 2;
               end
            endcase
         end
      end
   endtask

   initial begin
      limiter_on = 1'b1;
      step_cap = 24'd100;
      rate_cap = 32'd10000;
      keep_threshold = 33'h1_0000_0000;
      bypass_mask = '0;
      shift_state = DEFAULT_SEED;
      window_events = '0;
      sampling_on = 1'b0;
      events_seen = '0;
      events_passed = '0;
      for (int i = 0; i < TALLIED_TYPES; i++) type_tally[i] = '0;
      energy_max = '0;
      force_max = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_settings();
      test_random_traffic();
      send_idle = 83;
      recv_idle = 27;
      test_random_traffic();
      send_idle = 0;
      recv_idle = 0;
      test_random_traffic();
      wait_until_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && predicted_responses.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
